@@ sv/rspse_pkg.sv @@
package rspse_pkg;

    localparam int DATA_MEM_BYTES_DFLT = 4096;

    // Primary opcodes
    localparam logic [5:0] OP_SPECIAL = 6'h00;
    localparam logic [5:0] OP_REGIMM  = 6'h01;
    localparam logic [5:0] OP_J       = 6'h02;
    localparam logic [5:0] OP_JAL     = 6'h03;
    localparam logic [5:0] OP_BEQ     = 6'h04;
    localparam logic [5:0] OP_BNE     = 6'h05;
    localparam logic [5:0] OP_BLEZ    = 6'h06;
    localparam logic [5:0] OP_BGTZ    = 6'h07;
    localparam logic [5:0] OP_ADDI    = 6'h08;
    localparam logic [5:0] OP_ADDIU   = 6'h09;
    localparam logic [5:0] OP_SLTI    = 6'h0A;
    localparam logic [5:0] OP_SLTIU   = 6'h0B;
    localparam logic [5:0] OP_ANDI    = 6'h0C;
    localparam logic [5:0] OP_ORI     = 6'h0D;
    localparam logic [5:0] OP_XORI    = 6'h0E;
    localparam logic [5:0] OP_LUI     = 6'h0F;
    localparam logic [5:0] OP_COP0    = 6'h10;
    localparam logic [5:0] OP_LB      = 6'h20;
    localparam logic [5:0] OP_LH      = 6'h21;
    localparam logic [5:0] OP_LW      = 6'h23;
    localparam logic [5:0] OP_LBU     = 6'h24;
    localparam logic [5:0] OP_LHU     = 6'h25;
    localparam logic [5:0] OP_SB      = 6'h28;
    localparam logic [5:0] OP_SH      = 6'h29;
    localparam logic [5:0] OP_SW      = 6'h2B;

    // SPECIAL function codes
    localparam logic [5:0] FN_SLL   = 6'h00;
    localparam logic [5:0] FN_SRL   = 6'h02;
    localparam logic [5:0] FN_SRA   = 6'h03;
    localparam logic [5:0] FN_SLLV  = 6'h04;
    localparam logic [5:0] FN_SRLV  = 6'h06;
    localparam logic [5:0] FN_SRAV  = 6'h07;
    localparam logic [5:0] FN_JR    = 6'h08;
    localparam logic [5:0] FN_JALR  = 6'h09;
    localparam logic [5:0] FN_BREAK = 6'h0D;
    localparam logic [5:0] FN_ADD   = 6'h20;
    localparam logic [5:0] FN_ADDU  = 6'h21;
    localparam logic [5:0] FN_SUB   = 6'h22;
    localparam logic [5:0] FN_SUBU  = 6'h23;
    localparam logic [5:0] FN_AND   = 6'h24;
    localparam logic [5:0] FN_OR    = 6'h25;
    localparam logic [5:0] FN_XOR   = 6'h26;
    localparam logic [5:0] FN_NOR   = 6'h27;
    localparam logic [5:0] FN_SLT   = 6'h2A;
    localparam logic [5:0] FN_SLTU  = 6'h2B;

    // REGIMM rt codes
    localparam logic [4:0] RI_BLTZ   = 5'h00;
    localparam logic [4:0] RI_BGEZ   = 5'h01;
    localparam logic [4:0] RI_BLTZAL = 5'h10;
    localparam logic [4:0] RI_BGEZAL = 5'h11;

    // COP0 rs codes and registers
    localparam logic [4:0] C0_MF = 5'h00;
    localparam logic [4:0] C0_MT = 5'h04;
    localparam logic [4:0] C0R_DMA_LOCAL  = 5'd0;
    localparam logic [4:0] C0R_DMA_REMOTE = 5'd1;
    localparam logic [4:0] C0R_DMA_RD_LEN = 5'd2;
    localparam logic [4:0] C0R_DMA_WR_LEN = 5'd3;
    localparam logic [4:0] C0R_STATUS     = 5'd4;
    localparam logic [4:0] C0R_SEMAPHORE  = 5'd7;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_BREAK   = 2'd1;
    localparam logic [1:0] ST_UNHANDL = 2'd2;

    localparam logic [1:0] DMA_NONE   = 2'd0;
    localparam logic [1:0] DMA_RD_REQ = 2'd1;
    localparam logic [1:0] DMA_WR_REQ = 2'd2;

    localparam logic [4:0] RA_IDX = 5'd31;

    typedef struct packed {
        logic        branch;
        logic        taken;
        logic [12:0] target;
        logic        links;
        logic [4:0]  link_index;
        logic [4:0]  wb_index;
        logic [31:0] wb_value;
        logic [1:0]  status;
        logic [1:0]  dma_kind;
        logic [31:0] dma_length;
        logic [31:0] dma_local_addr;
        logic [31:0] dma_remote_addr;
    } t_res;

    // Fold an address into the 13-bit pc space with the base bit set
    function automatic logic [12:0] norm_pc(input logic [12:0] a);
        return {1'b1, a[11:0]};
    endfunction

endpackage

@@ sv/rsp_scalar_execute.sv @@
// Scalar execute stage of a MIPS-subset signal coprocessor.
// Input channel (s_axis): one beat carries one instruction word and its pc.
// Output channel (m_axis): one beat per instruction with its branch decision,
// register write-back, status and DMA request; status and DMA kind ride in
// tuser.
// Pipeline: accept (register file read) -> execute (ALU, branch, data memory
// read or write) -> load align -> output register. Throughput is one
// instruction per cycle while the receiver is ready. Results from instructions
// still in flight are forwarded to the operand read, so back-to-back
// dependent instructions, loads included, run without bubbles.
// Data memory: four byte banks, one synchronous port each, so any unaligned,
// wrapping access of up to four bytes is served by all four banks at once.
// DATA_MEM_BYTES must be a power of two.
//
// Reset clears the pipeline, the DMA address registers and all register file
// valid bits (so every register reads zero); data memory is left as is.
// When the receiver stalls, the output beat holds and the stages behind it
// keep filling until all are full, then s_axis_tready drops.
module rsp_scalar_execute #(
    parameter int DATA_MEM_BYTES = rspse_pkg::DATA_MEM_BYTES_DFLT
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // [31:0] instruction, [44:32] pc, [47:45] zero
    input  logic [47:0]  s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // [0] branch, [1] taken, [14:2] target, [15] links, [20:16] link_index,
    // [25:21] wb_index, [57:26] wb_value, [89:58] dma_length,
    // [121:90] dma_local_addr, [153:122] dma_remote_addr, [159:154] zero
    output logic [159:0] m_axis_tdata,
    // [1:0] status, [3:2] dma_kind
    output logic [3:0]   m_axis_tuser
);
    import rspse_pkg::*;

    localparam int AW   = $clog2(DATA_MEM_BYTES);
    localparam int RW   = AW - 2;
    localparam int ROWS = DATA_MEM_BYTES / 4;

    // ---------------- handshake and stage control ----------------
    logic s2_adv, s1_adv, s1_free, in_acc;
    logic r_s1_vld, r_s2_vld, r_out_vld;

    assign s2_adv        = r_s2_vld && (!r_out_vld || m_axis_tready);
    assign s1_adv        = r_s1_vld && (!r_s2_vld || s2_adv);
    assign s1_free       = !r_s1_vld || s1_adv;
    assign s_axis_tready = s1_free;
    assign in_acc        = s_axis_tvalid && s1_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_s2_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (in_acc) begin
                r_s1_vld <= 1'b1;
            end else if (s1_adv) begin
                r_s1_vld <= 1'b0;
            end
            if (s1_adv) begin
                r_s2_vld <= 1'b1;
            end else if (s2_adv) begin
                r_s2_vld <= 1'b0;
            end
            if (s2_adv) begin
                r_out_vld <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // ---------------- register file ----------------
    // One synchronous memory; valid bits give the all-zero reset state.
    logic [31:0] rf_mem [32];
    logic [31:0] r_rf_vld;
    logic [31:0] r_rf_a, r_rf_b;
    logic        r_rf_a_ok, r_rf_b_ok;
    logic [4:0]  in_rs, in_rt;
    logic [4:0]  s2_rf_idx;
    logic [31:0] s2_rf_val;
    logic        rf_we;

    assign in_rs = s_axis_tdata[25:21];
    assign in_rt = s_axis_tdata[20:16];
    assign rf_we = s2_adv && (s2_rf_idx != 5'd0);

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_rf_a <= rf_mem[in_rs];
            r_rf_b <= rf_mem[in_rt];
        end
        if (rf_we) begin
            rf_mem[s2_rf_idx] <= s2_rf_val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rf_vld  <= '0;
            r_rf_a_ok <= 1'b0;
            r_rf_b_ok <= 1'b0;
        end else begin
            if (in_acc) begin
                r_rf_a_ok <= r_rf_vld[in_rs];
                r_rf_b_ok <= r_rf_vld[in_rt];
            end
            if (rf_we) begin
                r_rf_vld[s2_rf_idx] <= 1'b1;
            end
        end
    end

    // ---------------- stage 1: execute ----------------
    logic [31:0] r_s1_ins;
    logic [12:0] r_s1_pc;

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_ins <= s_axis_tdata[31:0];
            r_s1_pc  <= s_axis_tdata[44:32];
        end
    end

    logic [4:0]  r_out_rf_idx;
    logic [31:0] r_out_rf_val;

    logic [5:0]  op, fn;
    logic [4:0]  rs, rt, rd, sa;
    logic [15:0] imm;
    logic [31:0] simm, opa, opb, ea;
    logic [12:0] btgt, jtgt, link_pc;
    logic        wr, lk, is_ld;
    logic [4:0]  lreg, widx;
    logic [31:0] wval;
    logic [31:0] r_dma_local, r_dma_remote, n_dma_local, n_dma_remote;
    logic [2:0]  st_bytes;
    t_res        res;
    logic [4:0]  s1_rf_idx;
    logic [31:0] s1_rf_val;

    assign op   = r_s1_ins[31:26];
    assign fn   = r_s1_ins[5:0];
    assign rs   = r_s1_ins[25:21];
    assign rt   = r_s1_ins[20:16];
    assign rd   = r_s1_ins[15:11];
    assign sa   = r_s1_ins[10:6];
    assign imm  = r_s1_ins[15:0];
    assign simm = {{16{imm[15]}}, imm};

    // Operand forwarding: stage 2 first, then the item most recently written.
    always_comb begin
        if (r_s2_vld && s2_rf_idx != 5'd0 && s2_rf_idx == rs) begin
            opa = s2_rf_val;
        end else if (r_out_rf_idx != 5'd0 && r_out_rf_idx == rs) begin
            opa = r_out_rf_val;
        end else begin
            opa = r_rf_a_ok ? r_rf_a : 32'd0;
        end
        if (r_s2_vld && s2_rf_idx != 5'd0 && s2_rf_idx == rt) begin
            opb = s2_rf_val;
        end else if (r_out_rf_idx != 5'd0 && r_out_rf_idx == rt) begin
            opb = r_out_rf_val;
        end else begin
            opb = r_rf_b_ok ? r_rf_b : 32'd0;
        end
    end

    assign ea      = opa + simm;
    assign btgt    = norm_pc(r_s1_pc + 13'd4 + {simm[10:0], 2'b00});
    assign jtgt    = norm_pc({r_s1_ins[10:0], 2'b00});
    assign link_pc = norm_pc(r_s1_pc + 13'd8);

    always_comb begin
        res          = '0;
        res.status   = ST_OK;
        res.dma_kind = DMA_NONE;
        wr           = 1'b0;
        lk           = 1'b0;
        is_ld        = 1'b0;
        lreg         = RA_IDX;
        widx         = 5'd0;
        wval         = 32'd0;
        st_bytes     = 3'd0;
        n_dma_local  = r_dma_local;
        n_dma_remote = r_dma_remote;
        unique case (op)
            OP_SPECIAL: begin
                unique case (fn)
                    FN_SLL:  begin wr = 1'b1; widx = rd; wval = opb << sa; end
                    FN_SRL:  begin wr = 1'b1; widx = rd; wval = opb >> sa; end
                    FN_SRA:  begin wr = 1'b1; widx = rd; wval = $signed(opb) >>> sa; end
                    FN_SLLV: begin wr = 1'b1; widx = rd; wval = opb << opa[4:0]; end
                    FN_SRLV: begin wr = 1'b1; widx = rd; wval = opb >> opa[4:0]; end
                    FN_SRAV: begin
                        wr = 1'b1; widx = rd; wval = $signed(opb) >>> opa[4:0];
                    end
                    FN_JR: begin
                        res.branch = 1'b1; res.taken = 1'b1;
                        res.target = norm_pc(opa[12:0]);
                    end
                    FN_JALR: begin
                        res.branch = 1'b1; res.taken = 1'b1; lk = 1'b1; lreg = rd;
                        res.target = norm_pc(opa[12:0]);
                    end
                    FN_BREAK: res.status = ST_BREAK;
                    FN_ADD, FN_ADDU: begin wr = 1'b1; widx = rd; wval = opa + opb; end
                    FN_SUB, FN_SUBU: begin wr = 1'b1; widx = rd; wval = opa - opb; end
                    FN_AND: begin wr = 1'b1; widx = rd; wval = opa & opb; end
                    FN_OR:  begin wr = 1'b1; widx = rd; wval = opa | opb; end
                    FN_XOR: begin wr = 1'b1; widx = rd; wval = opa ^ opb; end
                    FN_NOR: begin wr = 1'b1; widx = rd; wval = ~(opa | opb); end
                    FN_SLT: begin
                        wr = 1'b1; widx = rd;
                        wval = {31'd0, $signed(opa) < $signed(opb)};
                    end
                    FN_SLTU: begin wr = 1'b1; widx = rd; wval = {31'd0, opa < opb}; end
                    default: res.status = ST_UNHANDL;
                endcase
            end
            OP_REGIMM: begin
                if (rt == RI_BLTZ || rt == RI_BGEZ || rt == RI_BLTZAL || rt == RI_BGEZAL) begin
                    res.branch = 1'b1;
                    res.taken  = rt[0] ? !opa[31] : opa[31];
                    res.target = btgt;
                    lk         = rt[4];
                end else begin
                    res.status = ST_UNHANDL;
                end
            end
            OP_J: begin
                res.branch = 1'b1; res.taken = 1'b1; res.target = jtgt;
            end
            OP_JAL: begin
                res.branch = 1'b1; res.taken = 1'b1; res.target = jtgt; lk = 1'b1;
            end
            OP_BEQ: begin
                res.branch = 1'b1; res.taken = (opa == opb); res.target = btgt;
            end
            OP_BNE: begin
                res.branch = 1'b1; res.taken = (opa != opb); res.target = btgt;
            end
            OP_BLEZ: begin
                res.branch = 1'b1; res.target = btgt;
                res.taken  = (opa == 32'd0) || opa[31];
            end
            OP_BGTZ: begin
                res.branch = 1'b1; res.target = btgt;
                res.taken  = (opa != 32'd0) && !opa[31];
            end
            OP_ADDI, OP_ADDIU: begin wr = 1'b1; widx = rt; wval = ea; end
            OP_SLTI: begin
                wr = 1'b1; widx = rt; wval = {31'd0, $signed(opa) < $signed(simm)};
            end
            OP_SLTIU: begin wr = 1'b1; widx = rt; wval = {31'd0, opa < simm}; end
            OP_ANDI: begin wr = 1'b1; widx = rt; wval = opa & {16'd0, imm}; end
            OP_ORI:  begin wr = 1'b1; widx = rt; wval = opa | {16'd0, imm}; end
            OP_XORI: begin wr = 1'b1; widx = rt; wval = opa ^ {16'd0, imm}; end
            OP_LUI:  begin wr = 1'b1; widx = rt; wval = {imm, 16'd0}; end
            OP_COP0: begin
                if (rs == C0_MF) begin
                    wr = 1'b1; widx = rt; wval = 32'd0;
                end else if (rs == C0_MT) begin
                    unique case (rd)
                        C0R_DMA_LOCAL:  n_dma_local  = opb;
                        C0R_DMA_REMOTE: n_dma_remote = opb;
                        C0R_DMA_RD_LEN: begin
                            res.dma_kind = DMA_RD_REQ; res.dma_length = opb;
                        end
                        C0R_DMA_WR_LEN: begin
                            res.dma_kind = DMA_WR_REQ; res.dma_length = opb;
                        end
                        // status and semaphore writes have no visible effect here
                        C0R_STATUS, C0R_SEMAPHORE: ;
                        default: res.status = ST_UNHANDL;
                    endcase
                end else begin
                    res.status = ST_UNHANDL;
                end
            end
            OP_LB, OP_LH, OP_LW, OP_LBU, OP_LHU: begin
                wr = 1'b1; widx = rt; is_ld = 1'b1;
            end
            OP_SB: st_bytes = 3'd1;
            OP_SH: st_bytes = 3'd2;
            OP_SW: st_bytes = 3'd4;
            default: res.status = ST_UNHANDL;
        endcase

        if (wr && widx != 5'd0) begin
            res.wb_index = widx;
            res.wb_value = wval;
        end
        if (lk && lreg != 5'd0) begin
            res.links      = 1'b1;
            res.link_index = lreg;
        end
        res.dma_local_addr  = n_dma_local;
        res.dma_remote_addr = n_dma_remote;

        // At most one register write per instruction: write-back or link.
        if (res.links) begin
            s1_rf_idx = lreg;
            s1_rf_val = {19'd0, link_pc};
        end else begin
            s1_rf_idx = res.wb_index;
            s1_rf_val = res.wb_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dma_local  <= 32'd0;
            r_dma_remote <= 32'd0;
        end else if (s1_adv) begin
            r_dma_local  <= n_dma_local;
            r_dma_remote <= n_dma_remote;
        end
    end

    // ---------------- data memory: four byte banks ----------------
    logic [7:0]    st_byte [4];
    logic [7:0]    bank_wd [4];
    logic [RW-1:0] bank_row [4];
    logic [3:0]    bank_we;
    logic [7:0]    r_bank_q [4];

    always_comb begin
        st_byte[0] = opb[7:0];
        st_byte[1] = opb[7:0];
        st_byte[2] = opb[15:8];
        st_byte[3] = opb[7:0];
        case (st_bytes)
            3'd2: begin
                st_byte[0] = opb[15:8];
            end
            3'd4: begin
                st_byte[0] = opb[31:24];
                st_byte[1] = opb[23:16];
                st_byte[2] = opb[15:8];
            end
            default: ;
        endcase
    end

    // Byte i of the access lands in bank (ea + i) mod 4, at its own wrapped row.
    always_comb begin
        logic [1:0]    bi;
        logic [AW-1:0] baddr;
        for (int k = 0; k < 4; k++) begin
            bi          = 2'(k) - ea[1:0];
            baddr       = ea[AW-1:0] + AW'(bi);
            bank_row[k] = baddr[AW-1:2];
            bank_wd[k]  = st_byte[bi];
            bank_we[k]  = ({1'b0, bi} < st_bytes);
        end
    end

    for (genvar k = 0; k < 4; k++) begin : g_bank
        logic [7:0] mem_bank [ROWS];
        always_ff @(posedge i_clk) begin
            if (s1_adv) begin
                if (bank_we[k]) begin
                    mem_bank[bank_row[k]] <= bank_wd[k];
                end
                r_bank_q[k] <= mem_bank[bank_row[k]];
            end
        end
    end

    // ---------------- stage 2: load align ----------------
    t_res        r_s2_res;
    logic [4:0]  r_s2_rf_idx;
    logic [31:0] r_s2_rf_val;
    logic        r_s2_ld;
    logic [5:0]  r_s2_op;
    logic [1:0]  r_s2_ea_lo;
    logic [7:0]  ld_b0, ld_b1, ld_b2, ld_b3;
    logic [31:0] ld_val;
    t_res        s2_res;

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_s2_res    <= res;
            r_s2_rf_idx <= s1_rf_idx;
            r_s2_rf_val <= s1_rf_val;
            r_s2_ld     <= is_ld;
            r_s2_op     <= op;
            r_s2_ea_lo  <= ea[1:0];
        end
    end

    assign ld_b0 = r_bank_q[r_s2_ea_lo];
    assign ld_b1 = r_bank_q[r_s2_ea_lo + 2'd1];
    assign ld_b2 = r_bank_q[r_s2_ea_lo + 2'd2];
    assign ld_b3 = r_bank_q[r_s2_ea_lo + 2'd3];

    always_comb begin
        case (r_s2_op)
            OP_LB:   ld_val = {{24{ld_b0[7]}}, ld_b0};
            OP_LBU:  ld_val = {24'd0, ld_b0};
            OP_LH:   ld_val = {{16{ld_b0[7]}}, ld_b0, ld_b1};
            OP_LHU:  ld_val = {16'd0, ld_b0, ld_b1};
            default: ld_val = {ld_b0, ld_b1, ld_b2, ld_b3};
        endcase
    end

    always_comb begin
        s2_res    = r_s2_res;
        s2_rf_idx = r_s2_rf_idx;
        s2_rf_val = r_s2_rf_val;
        if (r_s2_ld && r_s2_rf_idx != 5'd0) begin
            s2_res.wb_value = ld_val;
            s2_rf_val       = ld_val;
        end
    end

    // ---------------- output register ----------------
    t_res r_out_res;

    always_ff @(posedge i_clk) begin
        if (s2_adv) begin
            r_out_res    <= s2_res;
            r_out_rf_val <= s2_rf_val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_rf_idx <= 5'd0;
        end else if (s2_adv) begin
            r_out_rf_idx <= s2_rf_idx;
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = {6'd0,
                            r_out_res.dma_remote_addr,
                            r_out_res.dma_local_addr,
                            r_out_res.dma_length,
                            r_out_res.wb_value,
                            r_out_res.wb_index,
                            r_out_res.link_index,
                            r_out_res.links,
                            r_out_res.target,
                            r_out_res.taken,
                            r_out_res.branch};
    assign m_axis_tuser  = {r_out_res.dma_kind, r_out_res.status};

endmodule

@@ sv/rspse_chk.sv @@
module rspse_chk (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         s_axis_tready,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [159:0] m_axis_tdata,
    input logic [3:0]   m_axis_tuser
);
    // A stalled output beat holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("output beat changed while stalled");

    // No beat right after reset.
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");

    // Input backpressure only comes from a stalled output beat.
    a_stall_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
        else $error("input not ready without an output stall");

    // A link only comes with a branch, and its branch target is in the upper half.
    a_link_branch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[15] |-> m_axis_tdata[0] && m_axis_tdata[14])
        else $error("link without branch or target outside pc space");

    // A non-branch reports no target; no write means zero value.
    a_clean_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[0] || m_axis_tdata[14:2] == 13'd0)
            && (m_axis_tdata[25:21] != 5'd0 || m_axis_tdata[57:26] == 32'd0))
        else $error("stale target or write-back value");

endmodule

bind rsp_scalar_execute rspse_chk u_rspse_chk (.*);
